>>> design/fcsa_pkg.sv
// shared types, constants and reciprocal table for the stripe address map
package fcsa_pkg;

  localparam int NUM_CHANNELS_DEF    = 8;
  localparam int CE_PER_CHANNEL_DEF  = 8;
  localparam int PLANES_PER_CE_DEF   = 2;
  localparam int PAGES_PER_BLOCK_DEF = 256;

  localparam int DATA_W = 32;
  localparam int DIV_W  = 9;

  typedef enum logic [1:0] {
    STATUS_OK           = 2'd0,
    STATUS_NO_CHANNEL   = 2'd1,
    STATUS_OFFSET_RANGE = 2'd2
  } status_t;

  typedef struct packed {
    logic        func;
    logic [19:0] object_id;
    logic [7:0]  mask;
    logic        empty;
  } fcsa_side0_t;

  typedef struct packed {
    fcsa_side0_t s0;
    logic [2:0]  k;
    logic        ovf;
  } fcsa_side1_t;

  typedef struct packed {
    fcsa_side1_t s1;
    logic [2:0]  ce;
  } fcsa_side2_t;

  typedef struct packed {
    fcsa_side2_t s2;
    logic        plane;
  } fcsa_side3_t;

  // floor(2^32 / n), all ones for n of one
  function automatic logic [DATA_W-1:0] recip_of(input logic [3:0] n);
    logic [DATA_W-1:0] r;
    case (n)
      4'd2:    r = 32'h8000_0000;
      4'd3:    r = 32'h5555_5555;
      4'd4:    r = 32'h4000_0000;
      4'd5:    r = 32'h3333_3333;
      4'd6:    r = 32'h2AAA_AAAA;
      4'd7:    r = 32'h2492_4924;
      4'd8:    r = 32'h2000_0000;
      default: r = 32'hFFFF_FFFF;
    endcase
    return r;
  endfunction

endpackage

>>> design/fcsa_div.sv
// two-stage divider by a small divisor using a supplied reciprocal
module fcsa_div import fcsa_pkg::*; #(
  parameter int W  = DATA_W,
  parameter int DW = DIV_W,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [W-1:0]  in_x,
  input  logic [DW-1:0] in_d,
  input  logic [W-1:0]  in_m,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [W-1:0]  out_q,
  output logic [DW-1:0] out_r,
  output logic [SW-1:0] out_side
);

  logic [2*W-1:0] prod_a;
  logic           va;
  logic [W-1:0]   xa;
  logic [W-1:0]   qa;
  logic [DW-1:0]  da;
  logic [SW-1:0]  sa;
  logic           ready_a;

  logic [W-1:0]   back_b;
  logic [W-1:0]   rem_b;
  logic           fix_b;
  logic           vb;
  logic [W-1:0]   qb;
  logic [DW-1:0]  rb;
  logic [DW-1:0]  db;
  logic [SW-1:0]  sb;
  logic           ready_b;

  assign ready_b  = !vb || out_ready;
  assign ready_a  = !va || ready_b;
  assign in_ready = ready_a;

  // estimate quotient, low by at most one
  assign prod_a = (2*W)'(in_x) * (2*W)'(in_m);

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (ready_a) begin
      va <= in_valid;
    end
    if (ready_a && in_valid) begin
      xa <= in_x;
      qa <= prod_a[2*W-1:W];
      da <= in_d;
      sa <= in_side;
    end
  end

  // correction step
  assign back_b = qa * W'(da);
  assign rem_b  = xa - back_b;
  assign fix_b  = rem_b >= W'(da);

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else if (ready_b) begin
      vb <= va;
    end
    if (ready_b && va) begin
      qb <= qa + W'(fix_b);
      rb <= fix_b ? DW'(rem_b - W'(da)) : DW'(rem_b);
      db <= da;
      sb <= sa;
    end
  end

  assign out_valid = vb;
  assign out_q     = qb;
  assign out_r     = rb;
  assign out_side  = sb;

  a_rem_below_div: assert property (@(posedge clk) disable iff (rst)
    vb |-> (rb < db))
    else $error("remainder not below divisor");

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    va |-> (da != '0))
    else $error("zero divisor in pipe");

endmodule

>>> design/fcsa_out.sv
// final stage: channel pick, status and output register
module fcsa_out import fcsa_pkg::*; #(
  parameter int CE_PER_CHANNEL  = CE_PER_CHANNEL_DEF,
  parameter int PLANES_PER_CE   = PLANES_PER_CE_DEF,
  parameter int PAGES_PER_BLOCK = PAGES_PER_BLOCK_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [DATA_W-1:0] in_block,
  input  logic [DIV_W-1:0]  in_page,
  input  fcsa_side3_t       in_side,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [47:0]       m_axis_tdata,
  output logic [1:0]        m_axis_tuser
);

  logic              ready_o;
  logic [3:0]        cnt;
  logic [2:0]        pick;
  logic              fault;
  logic              valid;
  logic [2:0]        channel;
  logic [2:0]        chip_enable;
  logic              plane_index;
  logic [31:0]       block_index;
  logic [7:0]        page_index;
  status_t           status;

  assign ready_o  = !valid || m_axis_tready;
  assign in_ready = ready_o;

  // k-th enabled channel
  always_comb begin
    cnt  = 4'd0;
    pick = 3'd0;
    for (int c = 0; c < 8; c++) begin
      if (in_side.s2.s1.s0.mask[c]) begin
        if (cnt == {1'b0, in_side.s2.s1.k}) pick = 3'(c);
        cnt = cnt + 4'd1;
      end
    end
  end

  assign fault = in_side.s2.s1.s0.empty || in_side.s2.s1.ovf;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ready_o) begin
      valid <= in_valid;
    end
    if (ready_o && in_valid) begin
      if (fault) begin
        channel     <= 3'd0;
        chip_enable <= 3'd0;
        plane_index <= 1'b0;
        block_index <= 32'd0;
        page_index  <= 8'd0;
        status      <= in_side.s2.s1.s0.empty ? STATUS_NO_CHANNEL : STATUS_OFFSET_RANGE;
      end else begin
        channel     <= pick;
        chip_enable <= in_side.s2.ce;
        plane_index <= in_side.plane;
        block_index <= in_side.s2.s1.s0.func ? {12'd0, in_side.s2.s1.s0.object_id}
                                             : in_block;
        page_index  <= in_page[7:0];
        status      <= STATUS_OK;
      end
    end
  end

  assign m_axis_tvalid = valid;
  assign m_axis_tdata  = {1'b0, page_index, block_index, plane_index, chip_enable, channel};
  assign m_axis_tuser  = status;

  a_fault_zero: assert property (@(posedge clk) disable iff (rst)
    (valid && status != STATUS_OK) |-> (channel == 3'd0 && chip_enable == 3'd0 &&
      plane_index == 1'b0 && block_index == 32'd0 && page_index == 8'd0))
    else $error("address fields set on a failed request");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    valid |-> (status == STATUS_OK || status == STATUS_NO_CHANNEL ||
               status == STATUS_OFFSET_RANGE))
    else $error("bad status code");

  a_fields_in_range: assert property (@(posedge clk) disable iff (rst)
    (valid && status == STATUS_OK) |-> (32'(page_index) < PAGES_PER_BLOCK &&
      32'(chip_enable) < CE_PER_CHANNEL && 32'(plane_index) < PLANES_PER_CE))
    else $error("address field out of geometry");

endmodule

>>> design/flash_channel_stripe_address.sv
// top level: flash page striping address map
//
// Maps a logical page, or an object id and offset, to channel, chip enable,
// plane, block and page, striping pages over enabled channels first.
// s_axis carries one request: tuser = func, tdata = logical_page,
// object_id, object_offset. m_axis returns one result per request:
// tdata = channel, chip_enable, plane_index, block_index, page_index,
// tuser = status (0 ok, 1 no channel enabled, 2 offset beyond one row).
// cfg_we / cfg_wdata write the channel enable mask; write it only while idle.
// The path runs through one input register, four dividers (by channel count,
// chip enables, planes, pages) and one output register. One request per cycle
// is accepted unless every stage holds a request while m_axis stalls.
// Reset sets the mask to all ones and empties the pipeline.
// When m_axis stalls each stage holds its request; empty stages still fill,
// and s_axis_tready drops only once every stage holds a request.
module flash_channel_stripe_address import fcsa_pkg::*; #(
  parameter int NUM_CHANNELS    = NUM_CHANNELS_DEF,
  parameter int CE_PER_CHANNEL  = CE_PER_CHANNEL_DEF,
  parameter int PLANES_PER_CE   = PLANES_PER_CE_DEF,
  parameter int PAGES_PER_BLOCK = PAGES_PER_BLOCK_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [87:0] s_axis_tdata,  // logical_page, object_id, object_offset
  input  logic        s_axis_tuser,  // func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,  // channel, chip_enable, plane_index, block_index, page_index
  output logic [1:0]  m_axis_tuser   // status
);

  localparam logic [7:0] LIVE_MASK = 8'((9'd1 << NUM_CHANNELS) - 9'd1);
  localparam logic [DATA_W-1:0] ROW_UNITS =
    32'(CE_PER_CHANNEL * PLANES_PER_CE * PAGES_PER_BLOCK);
  localparam logic [DATA_W-1:0] RECIP_CE = (CE_PER_CHANNEL == 1) ? 32'hFFFF_FFFF :
    32'((64'd1 << 32) / CE_PER_CHANNEL);
  localparam logic [DATA_W-1:0] RECIP_PL = (PLANES_PER_CE == 1) ? 32'hFFFF_FFFF :
    32'((64'd1 << 32) / PLANES_PER_CE);
  localparam logic [DATA_W-1:0] RECIP_PG = (PAGES_PER_BLOCK == 1) ? 32'hFFFF_FFFF :
    32'((64'd1 << 32) / PAGES_PER_BLOCK);

  logic [7:0]        channel_enable_mask;
  logic [7:0]        live;
  logic [3:0]        count;

  logic              v0;
  logic              ready0;
  logic [DATA_W-1:0] x0;
  logic [3:0]        n0;
  logic [DATA_W-1:0] m0;
  fcsa_side0_t       side0;

  logic              d0_valid, d0_ready;
  logic [DATA_W-1:0] d0_q;
  logic [DIV_W-1:0]  d0_r;
  fcsa_side0_t       d0_side;
  fcsa_side1_t       d1_side_in;

  logic              d1_valid, d1_ready;
  logic [DATA_W-1:0] d1_q;
  logic [DIV_W-1:0]  d1_r;
  fcsa_side1_t       d1_side;
  fcsa_side2_t       d2_side_in;

  logic              d2_valid, d2_ready;
  logic [DATA_W-1:0] d2_q;
  logic [DIV_W-1:0]  d2_r;
  fcsa_side2_t       d2_side;
  fcsa_side3_t       d3_side_in;

  logic              d3_valid, d3_ready;
  logic [DATA_W-1:0] d3_q;
  logic [DIV_W-1:0]  d3_r;
  fcsa_side3_t       d3_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_enable_mask <= 8'hFF;
    end else if (cfg_we) begin
      channel_enable_mask <= cfg_wdata;
    end
  end

  assign live = channel_enable_mask & LIVE_MASK;

  always_comb begin
    count = 4'd0;
    for (int c = 0; c < 8; c++) begin
      count = count + 4'(live[c]);
    end
  end

  // input register
  assign ready0        = !v0 || d0_ready;
  assign s_axis_tready = ready0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (ready0) begin
      v0 <= s_axis_tvalid;
    end
    if (ready0 && s_axis_tvalid) begin
      x0              <= s_axis_tuser ? s_axis_tdata[83:52] : s_axis_tdata[31:0];
      n0              <= (count == 4'd0) ? 4'd1 : count;
      m0              <= recip_of(count);
      side0.func      <= s_axis_tuser;
      side0.object_id <= s_axis_tdata[51:32];
      side0.mask      <= live;
      side0.empty     <= (count == 4'd0);
    end
  end

  fcsa_div #(.W(DATA_W), .DW(DIV_W), .SW($bits(fcsa_side0_t))) u_div_chan (
    .clk(clk), .rst(rst),
    .in_valid(v0), .in_ready(d0_ready),
    .in_x(x0), .in_d(DIV_W'(n0)), .in_m(m0), .in_side(side0),
    .out_valid(d0_valid), .out_ready(d1_ready),
    .out_q(d0_q), .out_r(d0_r), .out_side(d0_side)
  );

  assign d1_side_in.s0  = d0_side;
  assign d1_side_in.k   = d0_r[2:0];
  assign d1_side_in.ovf = d0_side.func && (d0_q >= ROW_UNITS);

  fcsa_div #(.W(DATA_W), .DW(DIV_W), .SW($bits(fcsa_side1_t))) u_div_ce (
    .clk(clk), .rst(rst),
    .in_valid(d0_valid), .in_ready(d1_ready),
    .in_x(d0_q), .in_d(DIV_W'(CE_PER_CHANNEL)), .in_m(RECIP_CE), .in_side(d1_side_in),
    .out_valid(d1_valid), .out_ready(d2_ready),
    .out_q(d1_q), .out_r(d1_r), .out_side(d1_side)
  );

  assign d2_side_in.s1 = d1_side;
  assign d2_side_in.ce = d1_r[2:0];

  fcsa_div #(.W(DATA_W), .DW(DIV_W), .SW($bits(fcsa_side2_t))) u_div_plane (
    .clk(clk), .rst(rst),
    .in_valid(d1_valid), .in_ready(d2_ready),
    .in_x(d1_q), .in_d(DIV_W'(PLANES_PER_CE)), .in_m(RECIP_PL), .in_side(d2_side_in),
    .out_valid(d2_valid), .out_ready(d3_ready),
    .out_q(d2_q), .out_r(d2_r), .out_side(d2_side)
  );

  assign d3_side_in.s2    = d2_side;
  assign d3_side_in.plane = d2_r[0];

  logic out_ready;

  fcsa_div #(.W(DATA_W), .DW(DIV_W), .SW($bits(fcsa_side3_t))) u_div_page (
    .clk(clk), .rst(rst),
    .in_valid(d2_valid), .in_ready(d3_ready),
    .in_x(d2_q), .in_d(DIV_W'(PAGES_PER_BLOCK)), .in_m(RECIP_PG), .in_side(d3_side_in),
    .out_valid(d3_valid), .out_ready(out_ready),
    .out_q(d3_q), .out_r(d3_r), .out_side(d3_side)
  );

  fcsa_out #(
    .CE_PER_CHANNEL(CE_PER_CHANNEL),
    .PLANES_PER_CE(PLANES_PER_CE),
    .PAGES_PER_BLOCK(PAGES_PER_BLOCK)
  ) u_out (
    .clk(clk), .rst(rst),
    .in_valid(d3_valid), .in_ready(out_ready),
    .in_block(d3_q), .in_page(d3_r), .in_side(d3_side),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

endmodule

>>> tb/sv/flash_channel_stripe_address_checker.sv
// checker for the stripe address map: predicts each request's address and compares results
`timescale 1ns / 100ps

module flash_channel_stripe_address_checker import fcsa_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [87:0] s_axis_tdata,  // logical_page, object_id, object_offset
  input  logic        s_axis_tuser,  // func
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [47:0] m_axis_tdata,  // channel, chip_enable, plane_index, block_index, page_index
  input  logic [1:0]  m_axis_tuser,  // status
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic [2:0]  channel;
    logic [2:0]  chip_enable;
    logic        plane_index;
    logic [31:0] block_index;
    logic [7:0]  page_index;
    status_t     status;
  } flash_addr_t;

  logic [7:0]  channel_mask;
  flash_addr_t expected_addr_q[$];

  function automatic flash_addr_t map_stripe_address(
    input logic        func,
    input logic [31:0] lpn,
    input logic [19:0] oid,
    input logic [31:0] ooff,
    input logic [7:0]  mask
  );
    flash_addr_t a;
    int unsigned n, per_plane, stripe, row, rem, off, k;
    logic        found;
    a = '0;
    a.status = STATUS_OK;
    found = 1'b0;
    n = $countones(mask);
    if (n == 0) begin
      a.status = STATUS_NO_CHANNEL;
      return a;
    end
    per_plane = n * CE_PER_CHANNEL_DEF;
    stripe = per_plane * PLANES_PER_CE_DEF;
    row = stripe * PAGES_PER_BLOCK_DEF;
    if (func == 1'b0) begin
      a.block_index = lpn / row;
      rem = lpn % row;
    end else begin
      if (ooff >= row) begin
        a.status = STATUS_OFFSET_RANGE;
        return a;
      end
      a.block_index = {12'd0, oid};
      rem = ooff;
    end
    a.page_index = 8'(rem / stripe);
    off = rem % stripe;
    a.plane_index = 1'(off / per_plane);
    off = off % per_plane;
    a.chip_enable = 3'(off / n);
    k = off % n;
    for (int c = 0; c < 8; c++) begin
      if (mask[c] && !found) begin
        if (k == 0) begin
          a.channel = 3'(c);
          found = 1'b1;
        end else begin
          k--;
        end
      end
    end
    return a;
  endfunction

  always @(posedge clk) begin
    flash_addr_t exp_addr, act_addr;
    if (rst) begin
      expected_addr_q.delete();
      channel_mask = 8'hFF;
      fail_count = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_addr_q.push_back(map_stripe_address(s_axis_tuser, s_axis_tdata[31:0],
                                                     s_axis_tdata[51:32], s_axis_tdata[83:52],
                                                     channel_mask));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        act_addr.channel     = m_axis_tdata[2:0];
        act_addr.chip_enable = m_axis_tdata[5:3];
        act_addr.plane_index = m_axis_tdata[6];
        act_addr.block_index = m_axis_tdata[38:7];
        act_addr.page_index  = m_axis_tdata[46:39];
        act_addr.status      = status_t'(m_axis_tuser);
        if (expected_addr_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("unexpected result: ch %0d ce %0d pl %0d blk %0d pg %0d st %0d",
                     act_addr.channel, act_addr.chip_enable, act_addr.plane_index,
                     act_addr.block_index, act_addr.page_index, act_addr.status);
          end
        end else begin
          exp_addr = expected_addr_q.pop_front();
          if (act_addr.channel != exp_addr.channel ||
              act_addr.chip_enable != exp_addr.chip_enable ||
              act_addr.plane_index != exp_addr.plane_index ||
              act_addr.block_index != exp_addr.block_index ||
              act_addr.page_index != exp_addr.page_index ||
              act_addr.status != exp_addr.status) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("mismatch: exp ch %0d ce %0d pl %0d blk %0d pg %0d st %0d",
                       exp_addr.channel, exp_addr.chip_enable, exp_addr.plane_index,
                       exp_addr.block_index, exp_addr.page_index, exp_addr.status);
              $display("          act ch %0d ce %0d pl %0d blk %0d pg %0d st %0d",
                       act_addr.channel, act_addr.chip_enable, act_addr.plane_index,
                       act_addr.block_index, act_addr.page_index, act_addr.status);
            end
          end
        end
      end
      if (cfg_we) begin
        channel_mask = cfg_wdata;
      end
    end
    pending = expected_addr_q.size();
  end

endmodule

>>> tb/sv/flash_channel_stripe_address_tb.sv
// testbench top for the stripe address map: clock, reset, request stimulus and verdict
`timescale 1ns / 100ps

module flash_channel_stripe_address_tb import fcsa_pkg::*;;

  localparam int SEGMENTS     = 10;
  localparam int SEG_REQUESTS = 150;
  localparam int DRAIN_CYCLES = 20;
  localparam int HOLD_CYCLES  = 120;
  localparam int CYCLE_LIMIT  = 300000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [7:0]  cfg_wdata = 8'd0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [87:0] s_axis_tdata = '0;  // logical_page, object_id, object_offset
  logic        s_axis_tuser = 1'b0;  // func
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;  // channel, chip_enable, plane_index, block_index, page_index
  logic [1:0]  m_axis_tuser;  // status

  int          fail_count;
  int          pending;
  int          cycle_count = 0;
  int          burst_left = 0;
  logic        steady = 1'b0;
  logic        hold_go = 1'b0;
  logic        hold_done = 1'b0;
  int          hold_cnt = 0;
  int          pat_left = 0;
  int          pat_mode = 0;
  logic [7:0]  mask_now = 8'hFF;

  flash_channel_stripe_address u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  flash_channel_stripe_address_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .fail_count    (fail_count),
    .pending       (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // receiver: one long hold-off on request, otherwise changing stall patterns
  always @(negedge clk) begin
    if (hold_go && !hold_done) begin
      m_axis_tready = 1'b0;
      hold_cnt++;
      if (hold_cnt >= HOLD_CYCLES) begin
        hold_done = 1'b1;
      end
    end else begin
      if (pat_left == 0) begin
        pat_mode = $urandom_range(0, 3);
        pat_left = $urandom_range(10, 80);
      end
      pat_left--;
      case (pat_mode)
        0: m_axis_tready = 1'b1;
        1: m_axis_tready = 1'($urandom_range(0, 1));
        2: m_axis_tready = ($urandom_range(0, 3) == 0);
        default: m_axis_tready = (pat_left % 3 != 0);
      endcase
    end
  end

  function automatic int unsigned row_size(input logic [7:0] mask);
    int unsigned n;
    n = $countones(mask);
    if (n == 0) begin
      n = 1;
    end
    return n * CE_PER_CHANNEL_DEF * PLANES_PER_CE_DEF * PAGES_PER_BLOCK_DEF;
  endfunction

  // entered and left at a falling edge
  task automatic send_request(input logic func, input logic [31:0] lpn,
                              input logic [19:0] oid, input logic [31:0] ooff);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (!steady) begin
        gap = $urandom_range(0, 6);
        repeat (gap) begin
          s_axis_tvalid = 1'b0;
          @(negedge clk);
        end
      end
    end
    burst_left--;
    s_axis_tvalid = 1'b1;
    s_axis_tuser = func;
    s_axis_tdata = {4'd0, ooff, oid, lpn};
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    s_axis_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_mask(input logic [7:0] mask);
    wait_drained();
    cfg_wdata = mask;
    cfg_we = 1'b1;
    @(negedge clk);
    cfg_we = 1'b0;
    mask_now = mask;
  endtask

  task automatic random_request();
    logic        func;
    logic [31:0] lpn, ooff;
    logic [19:0] oid;
    int unsigned row;
    row = row_size(mask_now);
    func = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 3))
      0: lpn = $urandom;
      1: lpn = $urandom_range(0, row * 3);
      2: lpn = 32'hFFFF_FFFF - $urandom_range(0, row);
      default: lpn = row * $urandom_range(0, 9) + $urandom_range(0, 1) - 1;
    endcase
    case ($urandom_range(0, 9))
      7: ooff = row + $urandom_range(0, 10);
      8: ooff = row - 1;
      9: ooff = $urandom;
      default: ooff = $urandom_range(0, row - 1);
    endcase
    case ($urandom_range(0, 7))
      0: oid = 20'd0;
      1: oid = 20'hFFFFF;
      default: oid = 20'($urandom);
    endcase
    send_request(func, lpn, oid, ooff);
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst = 1'b0;

    // all channels enabled after reset
    send_request(1'b0, 32'd0, 20'd0, 32'd0);
    send_request(1'b0, 32'd1, 20'd0, 32'd0);
    send_request(1'b0, 32'd7, 20'd0, 32'd0);
    send_request(1'b0, 32'd8, 20'd0, 32'd0);
    send_request(1'b0, 32'd63, 20'd0, 32'd0);
    send_request(1'b0, 32'd64, 20'd0, 32'd0);
    send_request(1'b0, 32'd127, 20'd0, 32'd0);
    send_request(1'b0, 32'd32767, 20'd0, 32'd0);
    send_request(1'b0, 32'd32768, 20'd0, 32'd0);
    send_request(1'b0, 32'hFFFF_FFFF, 20'hFFFFF, 32'hFFFF_FFFF);
    send_request(1'b1, 32'd0, 20'd0, 32'd0);
    send_request(1'b1, 32'hFFFF_FFFF, 20'hFFFFF, 32'd32767);
    send_request(1'b1, 32'd0, 20'd12345, 32'd32768);
    send_request(1'b1, 32'd0, 20'd7, 32'hFFFF_FFFF);
    send_request(1'b1, 32'd0, 20'd99, 32'd100);

    // no channel enabled
    write_mask(8'h00);
    send_request(1'b0, 32'd12345, 20'd1, 32'd1);
    send_request(1'b1, 32'd0, 20'd5, 32'hFFFF_FFFF);
    send_request(1'b1, 32'd0, 20'd5, 32'd0);

    // single high channel
    write_mask(8'h80);
    send_request(1'b1, 32'd0, 20'd3, 32'd4095);
    send_request(1'b1, 32'd0, 20'd3, 32'd4096);
    send_request(1'b0, 32'd4096, 20'd0, 32'd0);

    // sparse mask
    write_mask(8'hA5);
    send_request(1'b0, 32'd3, 20'd0, 32'd0);
    send_request(1'b0, 32'd33, 20'd0, 32'd0);
    send_request(1'b1, 32'd0, 20'd42, 32'd16383);

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case (seg)
        0: write_mask(8'hFF);
        1: write_mask(8'h01);
        2: write_mask(8'h80);
        3: write_mask(8'h00);
        4: write_mask(8'h7F);
        default: write_mask(8'($urandom));
      endcase
      steady = (seg == 1);
      for (int i = 0; i < SEG_REQUESTS; i++) begin
        if (seg == 1 && i == 0) begin
          hold_go = 1'b1;
        end
        random_request();
      end
    end
    steady = 1'b0;

    wait_drained();
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
